@@ sv/spq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY     = 16;
   localparam int PAYLOAD_BITS = 16;

   localparam int KEY_BITS       = 8;
   localparam int PAY_FIELD_BITS = 16;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_BITS     = 5;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 56;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ sv/sorted_priority_queue_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded max-priority queue kept sorted in a row of cells.
// ----------------------------------------------------------------------------
// Takes one insert or remove transfer per clock while no result is stalled,
// and returns one result per transfer in the next cycle. Entries sit in a
// row of CAPACITY cells with the highest key in cell 0; every cell compares
// its key with the incoming one in parallel and shifts toward or away from
// the head, so the rate is set by that one compare per cell. A result
// register decouples the two sides: a new request is taken while the held
// result is being taken. Equal keys leave newest first. Insert on a full
// queue and remove on an empty one return a status code and change nothing.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
   parameter int CAPACITY     = spq_pkg::CAPACITY,
   parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [7:0] key, [23:8] payload
   input  wire logic [spq_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [0] req_type
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [1:0] status, [17:2] removed_payload, [25:18] removed_key,
   // [26] top_valid, [42:27] top_payload, [50:43] top_key, [55:51] entry_count
   output logic [spq_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PV = (PAYLOAD_BITS < spq_pkg::PAY_FIELD_BITS) ?
                       PAYLOAD_BITS : spq_pkg::PAY_FIELD_BITS;

   logic [CW-1:0]                      count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;

   logic                               accept;
   logic                               do_insert, do_remove;
   spq_pkg::cell_ctrl_type             ctrl;
   logic [spq_pkg::KEY_BITS-1:0]       new_key;
   logic [PAYLOAD_BITS-1:0]            new_payload;

   logic [spq_pkg::KEY_BITS-1:0]       cell_key     [CAPACITY];
   logic [PAYLOAD_BITS-1:0]            cell_payload [CAPACITY];
   logic                               cell_greater [CAPACITY];
   logic                               cell_valid   [CAPACITY];

   spq_pkg::status_type                status;
   logic [spq_pkg::KEY_BITS-1:0]       rem_key, top_key;
   logic [PAYLOAD_BITS-1:0]            rem_payload, top_payload;
   logic                               top_valid;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign new_key     = req_tdata[spq_pkg::KEY_BITS-1:0];
   assign new_payload = PAYLOAD_BITS'(req_tdata[spq_pkg::KEY_BITS +: PV]);

   assign do_insert = accept && (req_tuser == spq_pkg::REQ_INSERT)
                      && (count_ff != CW'(CAPACITY));
   assign do_remove = accept && (req_tuser == spq_pkg::REQ_REMOVE)
                      && (count_ff != '0);
   assign ctrl.insert = do_insert;
   assign ctrl.remove = do_remove;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                          prev_gt;
      logic [spq_pkg::KEY_BITS-1:0]  prev_k, next_k;
      logic [PAYLOAD_BITS-1:0]       prev_p, next_p;

      assign cell_valid[i] = count_ff > CW'(i);

      if (i == 0) begin : g_head
         assign prev_gt = 1'b1;
         assign prev_k  = new_key;
         assign prev_p  = new_payload;
      end else begin : g_body
         assign prev_gt = cell_greater[i-1];
         assign prev_k  = cell_key[i-1];
         assign prev_p  = cell_payload[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_k = cell_key[i];
         assign next_p = cell_payload[i];
      end else begin : g_inner
         assign next_k = cell_key[i+1];
         assign next_p = cell_payload[i+1];
      end

      spq_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .valid        (cell_valid[i]),
         .new_key      (new_key),
         .new_payload  (new_payload),
         .prev_greater (prev_gt),
         .prev_key     (prev_k),
         .prev_payload (prev_p),
         .next_key     (next_k),
         .next_payload (next_p),
         .greater      (cell_greater[i]),
         .key          (cell_key[i]),
         .payload      (cell_payload[i])
      );
   end

   always_comb begin
      status      = spq_pkg::ST_DONE;
      count_in    = count_ff;
      rem_key     = '0;
      rem_payload = '0;
      if (accept && (req_tuser == spq_pkg::REQ_INSERT) && !do_insert) begin
         status = spq_pkg::ST_FULL;
      end
      if (accept && (req_tuser == spq_pkg::REQ_REMOVE) && !do_remove) begin
         status = spq_pkg::ST_EMPTY;
      end
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_remove) begin
         count_in    = count_ff - CW'(1);
         rem_key     = cell_key[0];
         rem_payload = cell_payload[0];
      end

      top_valid   = count_in != '0;
      top_key     = '0;
      top_payload = '0;
      if (top_valid) begin
         priority if (do_insert && !cell_greater[0]) begin
            top_key     = new_key;
            top_payload = new_payload;
         end else if (do_remove) begin
            top_key     = cell_key[1];
            top_payload = cell_payload[1];
         end else begin
            top_key     = cell_key[0];
            top_payload = cell_payload[0];
         end
      end

      rsp_data_in = {spq_pkg::COUNT_BITS'(count_in),
                     top_key,
                     spq_pkg::PAY_FIELD_BITS'(top_payload[PV-1:0]),
                     top_valid,
                     rem_key,
                     spq_pkg::PAY_FIELD_BITS'(rem_payload[PV-1:0]),
                     status};
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

@@ sv/spq_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, compares it with the incoming
// key and takes its own, the new or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS
) (
   input  wire logic                          clock,
   input  wire spq_pkg::cell_ctrl_type        ctrl,
   input  wire logic                          valid,
   input  wire logic [spq_pkg::KEY_BITS-1:0]  new_key,
   input  wire logic [PAYLOAD_BITS-1:0]       new_payload,
   input  wire logic                          prev_greater,
   input  wire logic [spq_pkg::KEY_BITS-1:0]  prev_key,
   input  wire logic [PAYLOAD_BITS-1:0]       prev_payload,
   input  wire logic [spq_pkg::KEY_BITS-1:0]  next_key,
   input  wire logic [PAYLOAD_BITS-1:0]       next_payload,
   output logic                               greater,
   output logic [spq_pkg::KEY_BITS-1:0]       key,
   output logic [PAYLOAD_BITS-1:0]            payload
);

   logic [spq_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]      payload_ff, payload_in;

   always_comb begin
      greater    = valid && (key_ff > new_key);
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctrl.insert) begin
         if (!greater) begin
            if (prev_greater) begin
               key_in     = new_key;
               payload_in = new_payload;
            end else begin
               key_in     = prev_key;
               payload_in = prev_payload;
            end
         end
      end else if (ctrl.remove) begin
         key_in     = next_key;
         payload_in = next_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule
`default_nettype wire

@@ sv/spq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [spq_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   logic [1:0]  status;
   logic [4:0]  count;
   logic        top_v;
   logic [23:0] removed;

   assign status  = rsp_tdata[1:0];
   assign removed = rsp_tdata[25:2];
   assign top_v   = rsp_tdata[26];
   assign count   = rsp_tdata[55:51];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_top_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (top_v == (count != 5'd0)))
      else $error("top_valid disagrees with entry_count");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == spq_pkg::ST_EMPTY) |-> (count == 5'd0) && !top_v)
      else $error("empty status with entries held");

   a_no_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status != spq_pkg::ST_DONE) |-> (removed == 24'd0))
      else $error("removed entry reported on refused transfer");

   a_req_after_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted transfer produced no result");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
